>>> rtl/rxrf_pkg.sv
// Shared types and constants for the receive ring with realtime command filter.
`default_nettype none
package rxrf_pkg;

  localparam int BYTE_W    = 8;
  localparam int CNT_OUT_W = 7;
  localparam int NUM_CODES = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATUS = 3'd0,
    REG_START  = 3'd1,
    REG_HOLD   = 3'd2,
    REG_DOOR   = 3'd3,
    REG_ABORT  = 3'd4
  } reg_idx_e;

  // request bit positions, also the priority order of the code compare
  localparam int REQ_STATUS = 0;
  localparam int REQ_START  = 1;
  localparam int REQ_HOLD   = 2;
  localparam int REQ_DOOR   = 3;
  localparam int REQ_ABORT  = 4;

  localparam logic [BYTE_W-1:0] STATUS_CODE_RST = 8'd63;
  localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd126;
  localparam logic [BYTE_W-1:0] HOLD_CODE_RST   = 8'd33;
  localparam logic [BYTE_W-1:0] DOOR_CODE_RST   = 8'd132;
  localparam logic [BYTE_W-1:0] ABORT_CODE_RST  = 8'd24;

  localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    read_data;
    logic                 read_empty;
    logic [CNT_OUT_W-1:0] fill_count;
    logic [CNT_OUT_W-1:0] free_space;
    logic                 dropped;
    logic                 status_req;
    logic                 start_req;
    logic                 hold_req;
    logic                 door_req;
    logic                 abort_req;
  } out_t;

  typedef enum logic [2:0] {
    CMD_STORE,
    CMD_REQ,
    CMD_POP,
    CMD_FLUSH,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [BYTE_W-1:0]    data;
    logic [NUM_CODES-1:0] req;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } bk_state_e;

endpackage
`default_nettype wire

>>> rtl/rx_ring_with_realtime_filter_top.sv
// Receive byte ring with realtime command filter, top level.
// Path: an accepted item goes into the command queue, then the back end registers the
// result and raises out_valid. Throughput: one item per cycle while out_ready allows;
// a pop that finds data holds the back end in BK_POP: the ring read port is registered.
// Reset (rst, synchronous): pointers and fill count cleared, codes back to defaults;
// stored bytes are not cleared and no clearing pass runs.
`default_nettype none
module rx_ring_with_realtime_filter_top #(
  parameter int DEPTH = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rxrf_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rxrf_pkg::out_t                      out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rxrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rxrf_pkg::BYTE_W-1:0]    cfg_data
);
  import rxrf_pkg::*;

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_data;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_data;

  rxrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  rxrf_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  rxrf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/rxrf_front.sv
// Front end: realtime code registers and classification of incoming items.
`default_nettype none
module rxrf_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire rxrf_pkg::in_t                          in_data,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [rxrf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [rxrf_pkg::BYTE_W-1:0]            cfg_data,
  output logic                                        cmd_valid,
  input  wire logic                                   cmd_ready,
  output rxrf_pkg::cmd_t                              cmd_data
);
  import rxrf_pkg::*;

  logic [BYTE_W-1:0]    codes [NUM_CODES];
  logic [NUM_CODES-1:0] hit;
  logic [NUM_CODES-1:0] req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes[REQ_STATUS] <= STATUS_CODE_RST;
      codes[REQ_START]  <= START_CODE_RST;
      codes[REQ_HOLD]   <= HOLD_CODE_RST;
      codes[REQ_DOOR]   <= DOOR_CODE_RST;
      codes[REQ_ABORT]  <= ABORT_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STATUS: codes[REQ_STATUS] <= cfg_data;
        REG_START:  codes[REQ_START]  <= cfg_data;
        REG_HOLD:   codes[REQ_HOLD]   <= cfg_data;
        REG_DOOR:   codes[REQ_DOOR]   <= cfg_data;
        REG_ABORT:  codes[REQ_ABORT]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // first matching code wins
  always_comb begin
    for (int i = 0; i < NUM_CODES; i++) begin
      hit[i] = (in_data.rx_byte == codes[i]);
    end
    req = hit & ~(hit - NUM_CODES'(1)) ;
  end

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    cmd_data.data = in_data.rx_byte;
    cmd_data.req  = '0;
    case (in_data.opcode)
      OP_PUSH: begin
        if (hit != '0) begin
          cmd_data.kind = CMD_REQ;
          cmd_data.req  = req;
        end else begin
          cmd_data.kind = CMD_STORE;
        end
      end
      OP_POP:   cmd_data.kind = CMD_POP;
      OP_FLUSH: cmd_data.kind = CMD_FLUSH;
      default:  cmd_data.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/rxrf_cmdq.sv
// Two-entry command queue between front end and buffer back end.
`default_nettype none
module rxrf_cmdq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rxrf_pkg::cmd_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rxrf_pkg::cmd_t      out_data
);
  import rxrf_pkg::*;

  cmd_t       entries [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_sel];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (pop) begin
        rd_sel <= ~rd_sel;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_sel] <= in_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rxrf_back.sv
// Back end: byte ring storage, pointers, fill count and result register.
`default_nettype none
module rxrf_back #(
  parameter int DEPTH = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire rxrf_pkg::cmd_t cmd_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rxrf_pkg::out_t      out_data
);
  import rxrf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int XW = (PW + 1 > CNT_OUT_W) ? PW + 1 : CNT_OUT_W;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [PW-1:0] FULL = PW'(DEPTH - 1);

  logic [BYTE_W-1:0] byte_store [DEPTH];
  logic [BYTE_W-1:0] mem_q;

  bk_state_e state, state_next;
  logic [PW-1:0] write_ptr, write_ptr_next;
  logic [PW-1:0] read_ptr, read_ptr_next;
  logic [PW-1:0] count, count_next;
  logic          mem_we;
  logic          mem_re;
  logic          load;
  out_t          res;
  logic [XW-1:0] fill_x;
  logic [XW-1:0] free_x;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[write_ptr] <= cmd_data.data;
    end
    if (mem_re) begin
      mem_q <= byte_store[read_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      write_ptr <= '0;
      read_ptr  <= '0;
      count     <= '0;
    end else begin
      state     <= state_next;
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
      count     <= count_next;
    end
  end

  always_comb begin
    state_next     = state;
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    count_next     = count;
    cmd_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    load           = 1'b0;
    res            = '0;
    res.read_data  = EMPTY_BYTE;
    case (state)
      BK_IDLE: begin
        cmd_ready = !out_valid || out_ready;
        if (cmd_valid && cmd_ready) begin
          case (cmd_data.kind)
            CMD_STORE: begin
              load = 1'b1;
              if (count == FULL) begin
                res.dropped = 1'b1;
              end else begin
                mem_we         = 1'b1;
                write_ptr_next = (write_ptr == LAST) ? '0 : write_ptr + PW'(1);
                count_next     = count + PW'(1);
              end
            end
            CMD_REQ: begin
              load           = 1'b1;
              res.status_req = cmd_data.req[REQ_STATUS];
              res.start_req  = cmd_data.req[REQ_START];
              res.hold_req   = cmd_data.req[REQ_HOLD];
              res.door_req   = cmd_data.req[REQ_DOOR];
              res.abort_req  = cmd_data.req[REQ_ABORT];
            end
            CMD_POP: begin
              if (count == '0) begin
                load           = 1'b1;
                res.read_empty = 1'b1;
              end else begin
                // read data comes back next cycle
                mem_re        = 1'b1;
                read_ptr_next = (read_ptr == LAST) ? '0 : read_ptr + PW'(1);
                count_next    = count - PW'(1);
                state_next    = BK_POP;
              end
            end
            CMD_FLUSH: begin
              load          = 1'b1;
              read_ptr_next = write_ptr;
              count_next    = '0;
            end
            default: load = 1'b1;
          endcase
        end
      end
      BK_POP: begin
        // result slot is always free here: it was free when the pop was taken
        load          = 1'b1;
        res.read_data = mem_q;
        state_next    = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
    fill_x         = XW'(count_next);
    free_x         = XW'(FULL - count_next);
    res.fill_count = fill_x[CNT_OUT_W-1:0];
    res.free_space = free_x[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rxrf_checker.sv
// Port-level checks for the receive ring top level, with its bind.
`default_nettype none
module rxrf_checker #(
  parameter int DEPTH = 128
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire rxrf_pkg::out_t out_data
);
  import rxrf_pkg::*;

  localparam logic [CNT_OUT_W-1:0] CAP = CNT_OUT_W'(DEPTH - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> CNT_OUT_W'(out_data.fill_count + out_data.free_space) == CAP)
    else $error("fill count and free space disagree");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_empty |->
      out_data.read_data == EMPTY_BYTE && out_data.fill_count == '0 && !out_data.dropped)
    else $error("empty pop result inconsistent");

  a_req_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_data.status_req, out_data.start_req, out_data.hold_req,
                              out_data.door_req, out_data.abort_req,
                              out_data.dropped, out_data.read_empty}) <= 1)
    else $error("more than one request or flag in one result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rx_ring_with_realtime_filter_top rxrf_checker #(
  .DEPTH (DEPTH)
) u_rxrf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
